// ===== src/frs_pkg.sv =====
// shared phase codes, register indexes and result type for the feed motor sequencer
package frs_pkg;

  localparam int PHASE_W = 3;

  localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LEAVE  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SEEK   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SETTLE = 3'd3;
  localparam logic [PHASE_W-1:0] PH_WINDOW = 3'd4;
  localparam logic [PHASE_W-1:0] PH_GAP    = 3'd5;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_LEAVE_TICKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAVE_FLOOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAVE_HITS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEEK_TICKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOWS = 3'd5;

  localparam int ROT_W  = 8;
  localparam int HITS_W = 8;
  localparam int HIT_W  = 9;
  localparam int WIN_W  = 6;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef struct packed {
    logic             motor_on;
    logic             busy;
    logic             done;
    logic             fault;
    logic [ROT_W-1:0] remaining;
  } result_t;

endpackage

// ===== src/frs_step.sv =====
// next-state and result logic for one start or tick request
module frs_step #(
  parameter int TICK_BITS = 10
) (
  input  logic                          func,
  input  logic [frs_pkg::ROT_W-1:0]     rotations,
  input  logic                          sensor_level,
  input  logic [TICK_BITS-1:0]          leave_ticks,
  input  logic [TICK_BITS-1:0]          leave_floor,
  input  logic [frs_pkg::HITS_W-1:0]    leave_hits,
  input  logic [TICK_BITS-1:0]          seek_ticks,
  input  logic [frs_pkg::WIN_W-1:0]     window_len,
  input  logic [frs_pkg::WIN_W-1:0]     window_lows,
  input  logic [frs_pkg::PHASE_W-1:0]   phase_q,
  input  logic [frs_pkg::ROT_W-1:0]     rot_left_q,
  input  logic [frs_pkg::HIT_W-1:0]     hit_count_q,
  input  logic [TICK_BITS-1:0]          leave_cnt_q,
  input  logic [TICK_BITS-1:0]          seek_cnt_q,
  input  logic [frs_pkg::WIN_W-1:0]     win_cnt_q,
  input  logic [frs_pkg::WIN_W-1:0]     low_cnt_q,
  output logic [frs_pkg::PHASE_W-1:0]   phase_next,
  output logic [frs_pkg::ROT_W-1:0]     rot_left_next,
  output logic [frs_pkg::HIT_W-1:0]     hit_count_next,
  output logic [TICK_BITS-1:0]          leave_cnt_next,
  output logic [TICK_BITS-1:0]          seek_cnt_next,
  output logic [frs_pkg::WIN_W-1:0]     win_cnt_next,
  output logic [frs_pkg::WIN_W-1:0]     low_cnt_next,
  output frs_pkg::result_t              result
);
  import frs_pkg::*;

  logic                 flt;
  logic                 ok;
  logic [HIT_W-1:0]     hit_inc;
  logic [TICK_BITS-1:0] leave_dec;
  logic [TICK_BITS-1:0] seek_dec;
  logic [WIN_W-1:0]     win_dec;
  logic [WIN_W-1:0]     low_inc;
  logic [ROT_W-1:0]     rot_dec;
  logic                 high;

  assign high      = sensor_level;
  assign hit_inc   = hit_count_q + HIT_W'(1);
  assign leave_dec = leave_cnt_q - TICK_BITS'(1);
  assign seek_dec  = seek_cnt_q - TICK_BITS'(1);
  assign win_dec   = win_cnt_q - WIN_W'(1);
  assign low_inc   = low_cnt_q + WIN_W'(1);
  assign rot_dec   = rot_left_q - ROT_W'(1);

  always_comb begin
    phase_next     = phase_q;
    rot_left_next  = rot_left_q;
    hit_count_next = hit_count_q;
    leave_cnt_next = leave_cnt_q;
    seek_cnt_next  = seek_cnt_q;
    win_cnt_next   = win_cnt_q;
    low_cnt_next   = low_cnt_q;
    flt            = 1'b0;
    ok             = 1'b0;

    if (func == FUNC_START) begin
      if (phase_q == PH_IDLE) begin
        rot_left_next = rotations;
        if (rotations == '0) begin
          ok = 1'b1;
        end else begin
          // start of a rotation, leave-home skipped on an empty budget
          hit_count_next = '0;
          leave_cnt_next = leave_ticks;
          if (leave_ticks == '0) begin
            seek_cnt_next = seek_ticks;
            phase_next    = PH_SEEK;
            flt           = (seek_ticks == '0);
          end else begin
            phase_next = PH_LEAVE;
          end
        end
      end
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          phase_next = PH_IDLE;
        end
        PH_LEAVE: begin
          if (high) begin
            hit_count_next = hit_inc;
          end
          if (high && (hit_inc > {1'b0, leave_hits})) begin
            seek_cnt_next = seek_ticks;
            phase_next    = PH_SEEK;
            flt           = (seek_ticks == '0);
          end else if (leave_cnt_q < leave_floor) begin
            flt = 1'b1;
          end else begin
            leave_cnt_next = leave_dec;
            if (leave_dec == '0) begin
              seek_cnt_next = seek_ticks;
              phase_next    = PH_SEEK;
              flt           = (seek_ticks == '0);
            end
          end
        end
        PH_SEEK: begin
          if (!high) begin
            phase_next = PH_SETTLE;
          end else begin
            seek_cnt_next = seek_dec;
            flt           = (seek_dec == '0);
          end
        end
        PH_SETTLE: begin
          win_cnt_next = window_len;
          low_cnt_next = '0;
          phase_next   = (window_len == '0) ? PH_GAP : PH_WINDOW;
        end
        PH_WINDOW: begin
          if (!high) begin
            low_cnt_next = low_inc;
          end
          win_cnt_next = win_dec;
          if (win_dec == '0) begin
            if (low_cnt_next > window_lows) begin
              rot_left_next = rot_dec;
              if (rot_dec == '0) begin
                ok = 1'b1;
              end else begin
                hit_count_next = '0;
                leave_cnt_next = leave_ticks;
                if (leave_ticks == '0) begin
                  seek_cnt_next = seek_ticks;
                  phase_next    = PH_SEEK;
                  flt           = (seek_ticks == '0);
                end else begin
                  phase_next = PH_LEAVE;
                end
              end
            end else begin
              phase_next = PH_GAP;
            end
          end
        end
        PH_GAP: begin
          seek_cnt_next = seek_dec;
          if (seek_dec == '0) begin
            flt = 1'b1;
          end else begin
            phase_next = PH_SEEK;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    if (flt || ok) begin
      phase_next = PH_IDLE;
    end
  end

  assign result.busy      = (phase_next != PH_IDLE);
  assign result.motor_on  = (phase_next != PH_IDLE);
  assign result.done      = flt || ok;
  assign result.fault     = flt;
  assign result.remaining = rot_left_next;

endmodule

// ===== src/feed_motor_rotation_sequencer_top.sv =====
// top level of the feed motor rotation sequencer
//
// usage:
// - input channel (in_valid / in_stall) carries one request per item: func 0 is a
//   start request with a rotation count, func 1 is one timebase tick with a sensor
//   sample; every request produces exactly one result
// - output channel (out_valid / out_stall) carries motor_on, busy_res, done_res,
//   fault and remaining for the request just handled
// - the state is updated at the accepting edge and the result sits in the output
//   register from the next cycle
// - throughput is one request per cycle unless a held result is stalled, set by the
//   state update of the phase/counter registers; the output register lets a new
//   request in while the held result is taken in the same cycle
// - when the receiver stalls, the held result stays put and in_stall rises only
//   while that result is waiting and still stalled
// - configuration writes (cfg_we, cfg_index, cfg_data) land at the edge; indexes
//   past the last register are dropped; they should only be made while idle
// - reset (rst, synchronous) returns the phase to idle, clears all counters,
//   empties the output register and reloads the default register values
module feed_motor_rotation_sequencer_top #(
  parameter int TICK_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [frs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [((TICK_BITS > 8) ? TICK_BITS : 8)-1:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              func,
  input  logic [frs_pkg::ROT_W-1:0]         rotations,
  input  logic                              sensor_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              motor_on,
  output logic                              busy_res,
  output logic                              done_res,
  output logic                              fault,
  output logic [frs_pkg::ROT_W-1:0]         remaining
);
  import frs_pkg::*;

  // default register values, cut to the width of each register
  localparam logic [TICK_BITS-1:0] LEAVE_TICKS_RST = TICK_BITS'(600);
  localparam logic [TICK_BITS-1:0] LEAVE_FLOOR_RST = TICK_BITS'(20);
  localparam logic [TICK_BITS-1:0] SEEK_TICKS_RST  = TICK_BITS'(600);
  localparam logic [HITS_W-1:0]    LEAVE_HITS_RST  = HITS_W'(30);
  localparam logic [WIN_W-1:0]     WINDOW_LEN_RST  = WIN_W'(20);
  localparam logic [WIN_W-1:0]     WINDOW_LOWS_RST = WIN_W'(6);

  // configuration registers
  logic [TICK_BITS-1:0] leave_ticks;
  logic [TICK_BITS-1:0] leave_floor;
  logic [HITS_W-1:0]    leave_hits;
  logic [TICK_BITS-1:0] seek_ticks;
  logic [WIN_W-1:0]     window_len;
  logic [WIN_W-1:0]     window_lows;

  // sequencer state
  logic [PHASE_W-1:0]   phase_q;
  logic [ROT_W-1:0]     rot_left_q;
  logic [HIT_W-1:0]     hit_count_q;
  logic [TICK_BITS-1:0] leave_cnt_q;
  logic [TICK_BITS-1:0] seek_cnt_q;
  logic [WIN_W-1:0]     win_cnt_q;
  logic [WIN_W-1:0]     low_cnt_q;

  logic [PHASE_W-1:0]   phase_next;
  logic [ROT_W-1:0]     rot_left_next;
  logic [HIT_W-1:0]     hit_count_next;
  logic [TICK_BITS-1:0] leave_cnt_next;
  logic [TICK_BITS-1:0] seek_cnt_next;
  logic [WIN_W-1:0]     win_cnt_next;
  logic [WIN_W-1:0]     low_cnt_next;

  result_t step_res;
  result_t res_q;
  logic    in_take;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      leave_ticks <= LEAVE_TICKS_RST;
      leave_floor <= LEAVE_FLOOR_RST;
      leave_hits  <= LEAVE_HITS_RST;
      seek_ticks  <= SEEK_TICKS_RST;
      window_len  <= WINDOW_LEN_RST;
      window_lows <= WINDOW_LOWS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEAVE_TICKS: leave_ticks <= cfg_data[TICK_BITS-1:0];
        CFG_LEAVE_FLOOR: leave_floor <= cfg_data[TICK_BITS-1:0];
        CFG_LEAVE_HITS:  leave_hits  <= cfg_data[HITS_W-1:0];
        CFG_SEEK_TICKS:  seek_ticks  <= cfg_data[TICK_BITS-1:0];
        CFG_WINDOW_LEN:  window_len  <= cfg_data[WIN_W-1:0];
        CFG_WINDOW_LOWS: window_lows <= cfg_data[WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // a request may enter whenever the output register is empty or draining
  assign in_stall = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  frs_step #(
    .TICK_BITS (TICK_BITS)
  ) u_step (
    .func           (func),
    .rotations      (rotations),
    .sensor_level   (sensor_level),
    .leave_ticks    (leave_ticks),
    .leave_floor    (leave_floor),
    .leave_hits     (leave_hits),
    .seek_ticks     (seek_ticks),
    .window_len     (window_len),
    .window_lows    (window_lows),
    .phase_q        (phase_q),
    .rot_left_q     (rot_left_q),
    .hit_count_q    (hit_count_q),
    .leave_cnt_q    (leave_cnt_q),
    .seek_cnt_q     (seek_cnt_q),
    .win_cnt_q      (win_cnt_q),
    .low_cnt_q      (low_cnt_q),
    .phase_next     (phase_next),
    .rot_left_next  (rot_left_next),
    .hit_count_next (hit_count_next),
    .leave_cnt_next (leave_cnt_next),
    .seek_cnt_next  (seek_cnt_next),
    .win_cnt_next   (win_cnt_next),
    .low_cnt_next   (low_cnt_next),
    .result         (step_res)
  );

  // state update, only on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_q     <= PH_IDLE;
      rot_left_q  <= '0;
      hit_count_q <= '0;
      leave_cnt_q <= '0;
      seek_cnt_q  <= '0;
      win_cnt_q   <= '0;
      low_cnt_q   <= '0;
    end else if (in_take) begin
      phase_q     <= phase_next;
      rot_left_q  <= rot_left_next;
      hit_count_q <= hit_count_next;
      leave_cnt_q <= leave_cnt_next;
      seek_cnt_q  <= seek_cnt_next;
      win_cnt_q   <= win_cnt_next;
      low_cnt_q   <= low_cnt_next;
    end
  end

  // output register: valid bit under reset, payload loaded on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      res_q <= step_res;
    end
  end

  assign motor_on  = res_q.motor_on;
  assign busy_res  = res_q.busy;
  assign done_res  = res_q.done;
  assign fault     = res_q.fault;
  assign remaining = res_q.remaining;

  // a fault is always reported as the end of the sequence
  a_fault_with_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fault) |-> done_res)
    else $error("fault without done");

  // a finished sequence leaves the motor stopped
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (!busy_res && !motor_on))
    else $error("done while still busy");

  // a running sequence always has at least one rotation outstanding
  a_busy_has_rotations: assert property (@(posedge clk) disable iff (rst)
    (phase_q != PH_IDLE) |-> (rot_left_q != '0))
    else $error("busy with no rotations left");

endmodule

// ===== tb/tb_feed_motor_rotation_sequencer_top.sv =====
// self-checking testbench for the feed motor rotation sequencer top level
`timescale 1ns / 1ps

module tb_feed_motor_rotation_sequencer_top;
  import frs_pkg::*;

  localparam int TB_TICK_W = 10;
  localparam int CFG_W     = 10;

  // an index past the last register, the block must drop writes to it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  // register values after reset
  localparam logic [TB_TICK_W-1:0] DEF_LEAVE_TICKS = 10'd600;
  localparam logic [TB_TICK_W-1:0] DEF_LEAVE_FLOOR = 10'd20;
  localparam logic [HITS_W-1:0]    DEF_LEAVE_HITS  = 8'd30;
  localparam logic [TB_TICK_W-1:0] DEF_SEEK_TICKS  = 10'd600;
  localparam logic [WIN_W-1:0]     DEF_WINDOW_LEN  = 6'd20;
  localparam logic [WIN_W-1:0]     DEF_WINDOW_LOWS = 6'd6;

  // dut ports, all inputs known from time zero
  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 func         = 1'b0;
  logic [ROT_W-1:0]     rotations    = '0;
  logic                 sensor_level = 1'b0;
  logic                 out_stall    = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 motor_on;
  logic                 busy_res;
  logic                 done_res;
  logic                 fault;
  logic [ROT_W-1:0]     remaining;

  feed_motor_rotation_sequencer_top #(
    .TICK_BITS(TB_TICK_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .rotations    (rotations),
    .sensor_level (sensor_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .motor_on     (motor_on),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .fault        (fault),
    .remaining    (remaining)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // sequencer shadow: own copy of the registers and of the phase/counter state
  // ---------------------------------------------------------------------------
  logic [TB_TICK_W-1:0] c_leave_ticks;
  logic [TB_TICK_W-1:0] c_leave_floor;
  logic [HITS_W-1:0]    c_leave_hits;
  logic [TB_TICK_W-1:0] c_seek_ticks;
  logic [WIN_W-1:0]     c_win_len;
  logic [WIN_W-1:0]     c_win_lows;

  logic [PHASE_W-1:0]   p_phase;
  logic [ROT_W-1:0]     p_left;
  logic [HIT_W-1:0]     p_hits;
  logic [TB_TICK_W-1:0] p_leave;
  logic [TB_TICK_W-1:0] p_seek;
  logic [WIN_W-1:0]     p_wcnt;
  logic [WIN_W-1:0]     p_lows;

  // expected status words, oldest first
  result_t status_q[$];
  int      errors = 0;
  int      sent   = 0;
  bit      tx_calm = 1'b0;

  function automatic void shadow_reset();
    c_leave_ticks = DEF_LEAVE_TICKS;
    c_leave_floor = DEF_LEAVE_FLOOR;
    c_leave_hits  = DEF_LEAVE_HITS;
    c_seek_ticks  = DEF_SEEK_TICKS;
    c_win_len     = DEF_WINDOW_LEN;
    c_win_lows    = DEF_WINDOW_LOWS;
    p_phase = PH_IDLE;
    p_left  = '0;
    p_hits  = '0;
    p_leave = '0;
    p_seek  = '0;
    p_wcnt  = '0;
    p_lows  = '0;
  endfunction

  // load the seek budget, an empty budget is an immediate timeout
  function automatic logic open_seek();
    p_seek  = c_seek_ticks;
    p_phase = PH_SEEK;
    return (p_seek == '0);
  endfunction

  // zero leave ticks skips straight to seek-home
  function automatic logic start_rotation();
    p_hits  = '0;
    p_leave = c_leave_ticks;
    if (p_leave == '0) return open_seek();
    p_phase = PH_LEAVE;
    return 1'b0;
  endfunction

  // advance the shadow by one request and return the status it should produce
  function automatic result_t feed_step(logic fn, logic [ROT_W-1:0] rot, logic lvl);
    logic    flt;
    logic    ok;
    result_t r;
    flt = 1'b0;
    ok  = 1'b0;
    if (fn == FUNC_START) begin
      // a start while busy is dropped
      if (p_phase == PH_IDLE) begin
        p_left = rot;
        if (rot == '0) ok = 1'b1;
        else flt = start_rotation();
      end
    end else begin
      case (p_phase)
        PH_LEAVE: begin
          if (lvl) p_hits = p_hits + 9'd1;
          if (lvl && (p_hits > {1'b0, c_leave_hits})) begin
            flt = open_seek();
          end else if (p_leave < c_leave_floor) begin
            flt = 1'b1;
          end else begin
            p_leave = p_leave - 10'd1;
            if (p_leave == '0) flt = open_seek();
          end
        end
        PH_SEEK: begin
          if (!lvl) begin
            p_phase = PH_SETTLE;
          end else begin
            p_seek = p_seek - 10'd1;
            if (p_seek == '0) flt = 1'b1;
          end
        end
        PH_SETTLE: begin
          p_wcnt  = c_win_len;
          p_lows  = '0;
          p_phase = (c_win_len == '0) ? PH_GAP : PH_WINDOW;
        end
        PH_WINDOW: begin
          if (!lvl) p_lows = p_lows + 6'd1;
          p_wcnt = p_wcnt - 6'd1;
          if (p_wcnt == '0) begin
            if (p_lows > c_win_lows) begin
              p_left = p_left - 8'd1;
              if (p_left == '0) ok = 1'b1;
              else flt = start_rotation();
            end else begin
              p_phase = PH_GAP;
            end
          end
        end
        PH_GAP: begin
          p_seek = p_seek - 10'd1;
          if (p_seek == '0) flt = 1'b1;
          else p_phase = PH_SEEK;
        end
        default: p_phase = PH_IDLE;
      endcase
    end
    if (flt || ok) p_phase = PH_IDLE;
    r.motor_on  = (p_phase != PH_IDLE);
    r.busy      = (p_phase != PH_IDLE);
    r.done      = flt | ok;
    r.fault     = flt;
    r.remaining = p_left;
    return r;
  endfunction

  function automatic result_t status_of(logic on, logic dn, logic flt, logic [ROT_W-1:0] rem);
    result_t r;
    r.motor_on  = on;
    r.busy      = on;
    r.done      = dn;
    r.fault     = flt;
    r.remaining = rem;
    return r;
  endfunction

  // sensor level that keeps a rotation moving through its phases, with some noise
  function automatic logic pick_level();
    case (p_phase)
      PH_LEAVE:  return ($urandom_range(0, 99) < 85);
      PH_SEEK:   return ($urandom_range(0, 99) < 70);
      PH_WINDOW: return ($urandom_range(0, 99) < 25);
      default:   return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offer one request, hold it until taken, then record what it should produce
  task automatic send_item(input logic fn, input logic [ROT_W-1:0] rot, input logic lvl,
                           input bit typed, input result_t want);
    int      gap;
    result_t pred;
    if (sent % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    sent++;
    gap = tx_calm ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(0, 15));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= fn;
    rotations    <= rot;
    sensor_level <= lvl;
    do @(posedge clk); while (!(in_valid && !in_stall));
    pred = feed_step(fn, rot, lvl);
    // typed rows are checked against the hand-written value, the shadow still advances
    status_q.push_back(typed ? want : pred);
  endtask

  // run the current sequence out with high samples so the block ends up idle
  task automatic flush_sequence();
    while (p_phase != PH_IDLE) send_item(FUNC_TICK, '0, 1'b1, 1'b0, '0);
  endtask

  // stop offering and let every outstanding status come back
  task automatic drain();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_LEAVE_TICKS: c_leave_ticks = val[TB_TICK_W-1:0];
      CFG_LEAVE_FLOOR: c_leave_floor = val[TB_TICK_W-1:0];
      CFG_LEAVE_HITS:  c_leave_hits  = val[HITS_W-1:0];
      CFG_SEEK_TICKS:  c_seek_ticks  = val[TB_TICK_W-1:0];
      CFG_WINDOW_LEN:  c_win_len     = val[WIN_W-1:0];
      CFG_WINDOW_LOWS: c_win_lows    = val[WIN_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // directed table: a row is either a register write or one request
  // ---------------------------------------------------------------------------
  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
    logic                 fn;
    logic [ROT_W-1:0]     rot;
    logic                 lvl;
    bit                   typed;
    result_t              want;
  } row_t;

  row_t plan[$];

  function automatic row_t req_row(logic fn, logic [ROT_W-1:0] rot, logic lvl);
    row_t r;
    r = '{default: '0};
    r.fn  = fn;
    r.rot = rot;
    r.lvl = lvl;
    return r;
  endfunction

  function automatic row_t typed_row(logic fn, logic [ROT_W-1:0] rot, logic lvl, result_t want);
    row_t r;
    r = req_row(fn, rot, lvl);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    row_t r;
    r = '{default: '0};
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    return r;
  endfunction

  initial begin : stimulus
    logic [TB_TICK_W-1:0] lt, lf, st;
    logic [HITS_W-1:0]    lh;
    logic [WIN_W-1:0]     wl, wlo;
    logic                 fn, lvl;
    logic [ROT_W-1:0]     rot;
    bit                   ignored;
    bit                   run_out;
    int                   counted, quota;

    shadow_reset();
    run_out = 1'b0;

    // tick while idle, zero-rotation start, full count, then a start while busy
    plan.push_back(typed_row(FUNC_TICK,  8'd0,   1'b1, status_of(1'b0, 1'b0, 1'b0, 8'd0)));
    plan.push_back(typed_row(FUNC_START, 8'd0,   1'b0, status_of(1'b0, 1'b1, 1'b0, 8'd0)));
    plan.push_back(typed_row(FUNC_START, 8'd255, 1'b1, status_of(1'b1, 1'b0, 1'b0, 8'd255)));
    plan.push_back(typed_row(FUNC_START, 8'd3,   1'b0, status_of(1'b1, 1'b0, 1'b0, 8'd255)));
    plan.push_back(req_row(FUNC_TICK, 8'd0, 1'b1));
    plan.push_back(req_row(FUNC_TICK, 8'd0, 1'b0));
    // leave-home skipped, no window, tiny seek budget: runs out through the gap ticks
    plan.push_back(reg_row(CFG_LEAVE_TICKS, 10'd0));
    plan.push_back(reg_row(CFG_SEEK_TICKS,  10'd3));
    plan.push_back(reg_row(CFG_WINDOW_LEN,  10'd0));
    plan.push_back(reg_row(CFG_WINDOW_LOWS, 10'd0));
    plan.push_back(reg_row(CFG_LEAVE_FLOOR, 10'd0));
    plan.push_back(reg_row(CFG_LEAVE_HITS,  10'd0));
    plan.push_back(req_row(FUNC_START, 8'd2, 1'b0));
    plan.push_back(req_row(FUNC_TICK,  8'd0, 1'b0));
    plan.push_back(req_row(FUNC_TICK,  8'd0, 1'b1));
    plan.push_back(req_row(FUNC_TICK,  8'd0, 1'b0));
    plan.push_back(req_row(FUNC_TICK,  8'd0, 1'b0));
    plan.push_back(req_row(FUNC_TICK,  8'd0, 1'b1));
    plan.push_back(req_row(FUNC_TICK,  8'd0, 1'b0));
    plan.push_back(typed_row(FUNC_TICK, 8'd0, 1'b1, status_of(1'b0, 1'b1, 1'b1, 8'd2)));
    // empty seek budget faults on the start itself
    plan.push_back(reg_row(CFG_SEEK_TICKS, 10'd0));
    plan.push_back(typed_row(FUNC_START, 8'd1, 1'b1, status_of(1'b0, 1'b1, 1'b1, 8'd1)));
    // two-sample window with two lows completes the only rotation
    plan.push_back(reg_row(CFG_SEEK_TICKS, 10'd5));
    plan.push_back(reg_row(CFG_WINDOW_LEN, 10'd2));
    plan.push_back(req_row(FUNC_START, 8'd1, 1'b0));
    plan.push_back(req_row(FUNC_TICK,  8'd0, 1'b0));
    plan.push_back(req_row(FUNC_TICK,  8'd0, 1'b1));
    plan.push_back(req_row(FUNC_TICK,  8'd0, 1'b0));
    plan.push_back(typed_row(FUNC_TICK, 8'd0, 1'b0, status_of(1'b0, 1'b1, 1'b0, 8'd0)));
    // leave-home floor reached before enough highs
    plan.push_back(reg_row(CFG_LEAVE_TICKS, 10'd3));
    plan.push_back(reg_row(CFG_LEAVE_FLOOR, 10'd3));
    plan.push_back(reg_row(CFG_LEAVE_HITS,  10'd255));
    plan.push_back(req_row(FUNC_START, 8'd1, 1'b0));
    plan.push_back(req_row(FUNC_TICK,  8'd0, 1'b1));
    plan.push_back(typed_row(FUNC_TICK, 8'd0, 1'b1, status_of(1'b0, 1'b1, 1'b1, 8'd1)));
    // remaining holds the unfinished count while idle after the fault
    plan.push_back(typed_row(FUNC_TICK, 8'd0, 1'b0, status_of(1'b0, 1'b0, 1'b0, 8'd1)));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        // registers only change with nothing in flight, the running sequence
        // is run out under the new values before the next request row
        drain();
        write_reg(plan[i].idx, plan[i].val);
        run_out = 1'b1;
      end else begin
        if (run_out) begin
          flush_sequence();
          run_out = 1'b0;
        end
        send_item(plan[i].fn, plan[i].rot, plan[i].lvl, plan[i].typed, plan[i].want);
      end
    end
    flush_sequence();
    drain();

    // random part: one setting per pass, the first two at the extremes
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        lt = 10'd1023; lf = 10'd1023; lh = 8'd255; st = 10'd1023; wl = 6'd63; wlo = 6'd63;
        quota = 30;
      end else if (ph == 1) begin
        lt = 10'd1; lf = 10'd0; lh = 8'd0; st = 10'd1; wl = 6'd1; wlo = 6'd0;
        quota = 40;
      end else begin
        lt  = TB_TICK_W'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40));
        lf  = TB_TICK_W'($urandom_range(0, lt));
        lh  = HITS_W'($urandom_range(0, 12));
        st  = TB_TICK_W'(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 80));
        wl  = WIN_W'(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12));
        wlo = WIN_W'($urandom_range(0, wl));
        quota = 40;
      end
      write_reg(CFG_LEAVE_TICKS, lt);
      write_reg(CFG_LEAVE_FLOOR, lf);
      write_reg(CFG_LEAVE_HITS,  CFG_W'(lh));
      write_reg(CFG_SEEK_TICKS,  st);
      write_reg(CFG_WINDOW_LEN,  CFG_W'(wl));
      write_reg(CFG_WINDOW_LOWS, CFG_W'(wlo));
      write_reg(CFG_SPARE_IDX,   CFG_W'($urandom_range(0, 1023)));

      counted = 0;
      while (counted < quota) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: anything at all, including starts while busy
          fn  = 1'($urandom_range(0, 1));
          rot = ROT_W'($urandom_range(0, 255));
          lvl = 1'($urandom_range(0, 1));
        end else if (p_phase == PH_IDLE) begin
          fn  = FUNC_START;
          rot = ROT_W'(($urandom_range(0, 9) == 0) ? 0 :
                (($urandom_range(0, 3) == 0) ? $urandom_range(4, 255) : $urandom_range(1, 3)));
          lvl = 1'($urandom_range(0, 1));
        end else begin
          fn  = FUNC_TICK;
          rot = ROT_W'($urandom_range(0, 255));
          lvl = pick_level();
        end
        ignored = ((fn == FUNC_START) && (p_phase != PH_IDLE)) ||
                  ((fn == FUNC_TICK) && (p_phase == PH_IDLE));
        send_item(fn, rot, lvl, 1'b0, '0);
        if (!ignored) counted++;
      end
      flush_sequence();
      drain();
    end

    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && status_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // status side: random stall per status, calm stretches, one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : taker
    int hold;
    int taken;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      hold = calm ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(0, 15));
      // long hold-off while requests keep coming, so the block backs up its input
      if (taken == 200) hold = 300;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
    end
  end

  task automatic report_field(input string name, input logic [ROT_W-1:0] want,
                              input logic [ROT_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // compare every taken status with the oldest expectation
  always @(posedge clk) begin : check_status
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        errors++;
        $display("%0t: status with no request waiting, expected none, actual %b", $time,
                 {motor_on, busy_res, done_res, fault, remaining});
      end else begin
        want = status_q.pop_front();
        report_field("motor_on",  ROT_W'(want.motor_on), ROT_W'(motor_on));
        report_field("busy_res",  ROT_W'(want.busy),     ROT_W'(busy_res));
        report_field("done_res",  ROT_W'(want.done),     ROT_W'(done_res));
        report_field("fault",     ROT_W'(want.fault),    ROT_W'(fault));
        report_field("remaining", want.remaining,        remaining);
      end
    end
  end

  // watchdog on the whole run
  initial begin : watchdog
    #20000000;
    $display("simulation failed");
    $finish;
  end

endmodule
